>>> src/dnp_pkg.sv
// types, constants and calendar tables for the date next/previous day block
`default_nettype none

package dnp_pkg;

  localparam int YEAR_FIELD_W = 16;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;

  // divisibility by 25 over a 16-bit value: multiply by the inverse mod 2^16
  localparam logic [15:0] DIV25_INV = 16'd23593;
  localparam logic [15:0] DIV25_LIM = 16'd2621;

  typedef struct packed {
    logic [5:0]  day_in;
    logic [3:0]  month_in;
    logic [15:0] year_in;
  } in_t;

  typedef struct packed {
    logic        date_valid;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [15:0] next_year;
    logic [4:0]  prev_day;
    logic [3:0]  prev_month;
    logic [15:0] prev_year;
    logic [8:0]  ordinal_day;
  } out_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? DAYS_FEB_LEAP : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] cum;
    unique case (m)
      4'd1:    cum = 9'd0;
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

endpackage

`default_nettype wire

>>> src/dnp_stream_if.sv
// valid/ready channel interface carrying one payload struct
`default_nettype none

interface dnp_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/date_next_prev_day_of_year.sv
// date validity, next date, previous date and day of year
// throughput: one request per cycle while out_chan.ready stays high,
// set by the single pass through the date logic
// the result register takes a new date while the input register refills in the same cycle
// reset: synchronous active-low rst_n empties both stages; no other state
`default_nettype none

module date_next_prev_day_of_year #(
  parameter int YEAR_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  dnp_stream_if.sink   in_chan,
  dnp_stream_if.source out_chan
);

  localparam int YW = (YEAR_BITS < dnp_pkg::YEAR_FIELD_W) ? YEAR_BITS : dnp_pkg::YEAR_FIELD_W;

  logic         s1_vld_r;
  dnp_pkg::in_t s1_r;
  logic          out_vld_r;
  dnp_pkg::out_t out_r;
  dnp_pkg::out_t res_nxt;

  logic out_adv;
  logic in_take;

  assign out_adv = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !s1_vld_r || out_adv;
  assign in_take = in_chan.valid && in_chan.ready;

  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_vld_r <= in_chan.valid;
      end
      if (out_adv) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= in_chan.data;
    end
    if (out_adv && s1_vld_r) begin
      out_r <= res_nxt;
    end
  end

  // date logic
  logic [YW-1:0] yr;
  logic [15:0]   yz;
  logic [15:0]   prod;
  logic          div25;
  logic          leap;
  logic [3:0]    mon;
  logic [5:0]    dy;
  logic [4:0]    dim;
  logic          ok;
  logic          last;
  logic          is_dec;
  logic          is_jan;
  logic [3:0]    pm;
  logic [YW-1:0] ny;
  logic [YW-1:0] py;

  assign yr    = s1_r.year_in[YW-1:0];
  assign yz    = 16'(yr);
  assign prod  = 16'(yz * dnp_pkg::DIV25_INV);
  assign div25 = (prod <= dnp_pkg::DIV25_LIM);
  assign leap  = (yz[1:0] == 2'd0) && (!div25 || (yz[3:0] == 4'd0));
  assign mon   = s1_r.month_in;
  assign dy    = s1_r.day_in;
  assign dim   = dnp_pkg::month_days(mon, leap);
  assign ok    = (yr != '0) && (dim != 5'd0) && (dy != 6'd0) && (dy <= 6'(dim));
  assign last  = (dy == 6'(dim));
  assign is_dec = (mon == dnp_pkg::MONTH_DEC);
  assign is_jan = (mon == dnp_pkg::MONTH_JAN);
  assign pm    = is_jan ? dnp_pkg::MONTH_DEC : 4'(mon - 4'd1);
  assign ny    = (last && is_dec) ? YW'(yr + 1'b1) : yr;
  assign py    = (dy == 6'd1 && is_jan) ? YW'(yr - 1'b1) : yr;

  always_comb begin
    res_nxt = '0;
    if (ok) begin
      res_nxt.date_valid = 1'b1;
      if (last) begin
        res_nxt.next_day   = 5'd1;
        res_nxt.next_month = is_dec ? dnp_pkg::MONTH_JAN : 4'(mon + 4'd1);
      end else begin
        res_nxt.next_day   = 5'(dy + 6'd1);
        res_nxt.next_month = mon;
      end
      res_nxt.next_year = 16'(ny);
      if (dy == 6'd1) begin
        res_nxt.prev_month = pm;
        res_nxt.prev_day   = dnp_pkg::month_days(pm, leap);
      end else begin
        res_nxt.prev_month = mon;
        res_nxt.prev_day   = 5'(dy - 6'd1);
      end
      res_nxt.prev_year   = 16'(py);
      res_nxt.ordinal_day = 9'(dnp_pkg::days_before(mon) + 9'(dy)
                          + 9'((mon > dnp_pkg::MONTH_FEB) && leap));
    end
  end

  // checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.date_valid) |-> (out_r == '0))
    else $error("invalid date result not cleared");

  a_valid_months: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.date_valid) |->
      (out_r.next_month >= 4'd1 && out_r.next_month <= dnp_pkg::MONTH_DEC &&
       out_r.prev_month >= 4'd1 && out_r.prev_month <= dnp_pkg::MONTH_DEC))
    else $error("result month out of range");

  a_ordinal_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.date_valid) |->
      (out_r.ordinal_day >= 9'd1 && out_r.ordinal_day <= 9'd366))
    else $error("ordinal day out of range");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_vld_r)
    else $error("accepted request lost in input stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_adv) |=> out_vld_r)
    else $error("input stage did not move into result register");

endmodule

`default_nettype wire

>>> test/tb_date_next_prev_day_of_year.sv
// testbench for the date next/previous day block with directed and random dates
module tb_date_next_prev_day_of_year;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n;

  dnp_stream_if #(.data_t(dnp_pkg::in_t))  in_chan ();
  dnp_stream_if #(.data_t(dnp_pkg::out_t)) out_chan ();

  date_next_prev_day_of_year #(
    .YEAR_BITS(dnp_pkg::YEAR_FIELD_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  dnp_pkg::out_t answers_due[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  bit   in_gaps_on = 1'b1;
  bit   out_stalls_on = 1'b1;
  bit   long_hold_pending = 1'b0;

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // m must be 1..12
  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    case (m)
      4, 6, 9, 11:        return 30;
      dnp_pkg::MONTH_FEB: return leap_year(y) ? dnp_pkg::DAYS_FEB_LEAP : 28;
      default:            return 31;
    endcase
  endfunction

  function automatic int unsigned days_ahead_of(input int unsigned m);
    case (m)
      1:       return 0;
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      default: return 334;
    endcase
  endfunction

  function automatic dnp_pkg::out_t calendar_answer(input dnp_pkg::in_t req);
    dnp_pkg::out_t a;
    int unsigned   d, m, y, len;
    a = '0;
    d = req.day_in;
    m = req.month_in;
    y = req.year_in;
    if (y == 0 || m < dnp_pkg::MONTH_JAN || m > dnp_pkg::MONTH_DEC || d == 0) return a;
    len = month_length(m, y);
    if (d > len) return a;
    a.date_valid = 1'b1;
    if (d < len) begin
      a.next_day   = 5'(d + 1);
      a.next_month = 4'(m);
      a.next_year  = 16'(y);
    end else if (m < dnp_pkg::MONTH_DEC) begin
      a.next_day   = 5'd1;
      a.next_month = 4'(m + 1);
      a.next_year  = 16'(y);
    end else begin
      a.next_day   = 5'd1;
      a.next_month = dnp_pkg::MONTH_JAN;
      a.next_year  = 16'(y + 1);
    end
    if (d > 1) begin
      a.prev_day   = 5'(d - 1);
      a.prev_month = 4'(m);
      a.prev_year  = 16'(y);
    end else if (m > dnp_pkg::MONTH_JAN) begin
      a.prev_day   = 5'(month_length(m - 1, y));
      a.prev_month = 4'(m - 1);
      a.prev_year  = 16'(y);
    end else begin
      a.prev_day   = 5'(month_length(dnp_pkg::MONTH_DEC, y - 1));
      a.prev_month = dnp_pkg::MONTH_DEC;
      a.prev_year  = 16'(y - 1);
    end
    a.ordinal_day = 9'(days_ahead_of(m) + d
                       + ((m > dnp_pkg::MONTH_FEB && leap_year(y)) ? 1 : 0));
    return a;
  endfunction

  function automatic logic [15:0] pick_year();
    int unsigned y;
    case ($urandom_range(0, 4))
      0:       y = $urandom_range(1, 65535);
      1:       y = 400 * $urandom_range(1, 163) + $urandom_range(0, 2) - 1;
      2:       y = 100 * $urandom_range(1, 655) + $urandom_range(0, 2) - 1;
      3:       y = 4 * $urandom_range(1, 16383);
      default: y = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(65532, 65535);
    endcase
    return y[15:0];
  endfunction

  task automatic send_date(input logic [5:0] d, input logic [3:0] m, input logic [15:0] y);
    dnp_pkg::in_t req;
    int           gap;
    req.day_in   = d;
    req.month_in = m;
    req.year_in  = y;
    gap = in_gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= req;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    answers_due.push_back(calendar_answer(req));
  endtask

  task automatic send_valid_date();
    logic [15:0] y;
    logic [3:0]  m;
    int unsigned len, d;
    y = pick_year();
    m = 4'($urandom_range(dnp_pkg::MONTH_JAN, dnp_pkg::MONTH_DEC));
    len = month_length(m, y);
    case ($urandom_range(0, 3))
      0:       d = 1;
      1:       d = len;
      2:       d = len - 1;
      default: d = $urandom_range(1, len);
    endcase
    send_date(6'(d), m, y);
  endtask

  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  task automatic test_calendar_edges();
    send_date(6'd1,  dnp_pkg::MONTH_JAN, 16'd1);
    send_date(6'd31, dnp_pkg::MONTH_DEC, 16'd65535);
    send_date(6'd1,  dnp_pkg::MONTH_JAN, 16'd65535);
    send_date(6'd29, dnp_pkg::MONTH_FEB, 16'd2000);
    send_date(6'd29, dnp_pkg::MONTH_FEB, 16'd2024);
    send_date(6'd28, dnp_pkg::MONTH_FEB, 16'd2023);
    send_date(6'd1,  4'd3,               16'd2024);
    send_date(6'd1,  4'd3,               16'd1900);
    send_date(6'd31, dnp_pkg::MONTH_DEC, 16'd2024);
    send_date(6'd31, dnp_pkg::MONTH_JAN, 16'd1999);
    send_date(6'd30, 4'd4,               16'd2021);
    send_date(6'd15, 4'd6,               16'd1);
  endtask

  task automatic test_invalid_dates();
    send_date(6'd1,  dnp_pkg::MONTH_JAN, 16'd0);
    send_date(6'd10, 4'd0,               16'd2020);
    send_date(6'd10, 4'd13,              16'd2020);
    send_date(6'd0,  4'd5,               16'd2020);
    send_date(6'd63, 4'd15,              16'd65535);
    send_date(6'd29, dnp_pkg::MONTH_FEB, 16'd1900);
    send_date(6'd29, dnp_pkg::MONTH_FEB, 16'd2023);
    send_date(6'd31, 4'd4,               16'd2021);
    send_date(6'd32, dnp_pkg::MONTH_DEC, 16'd2021);
  endtask

  task automatic test_random_dates();
    for (int grp = 0; grp < 10; grp++) begin
      in_gaps_on    = $urandom_range(0, 1);
      out_stalls_on = $urandom_range(0, 1);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 4) != 0) begin
          send_valid_date();
        end else begin
          send_date(6'($urandom), 4'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  task automatic test_backpressure();
    in_gaps_on        = 1'b0;
    out_stalls_on     = 1'b0;
    long_hold_pending = 1'b1;
    for (int i = 0; i < 30; i++) send_valid_date();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  initial begin : result_side
    int            stall;
    dnp_pkg::out_t got, want;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 14) : 0;
      if (long_hold_pending) begin
        stall = LONG_HOLD_CYCLES;
        long_hold_pending = 1'b0;
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      got = out_chan.data;
      if (answers_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no request pending, expected none, got %p", $time, got);
      end else begin
        want = answers_due.pop_front();
        check_field("date_valid",  want.date_valid,  got.date_valid);
        check_field("next_day",    want.next_day,    got.next_day);
        check_field("next_month",  want.next_month,  got.next_month);
        check_field("next_year",   want.next_year,   got.next_year);
        check_field("prev_day",    want.prev_day,    got.prev_day);
        check_field("prev_month",  want.prev_month,  got.prev_month);
        check_field("prev_year",   want.prev_year,   got.prev_year);
        check_field("ordinal_day", want.ordinal_day, got.ordinal_day);
      end
    end
  end

  initial begin : request_side
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_calendar_edges();
    test_invalid_dates();
    test_backpressure();
    test_random_dates();
    in_chan.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/dnp_pkg.sv
src/dnp_stream_if.sv
src/date_next_prev_day_of_year.sv
test/tb_date_next_prev_day_of_year.sv
